/* src/gtg_pkg.sv */
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types, constants and tables for the go-to-goal controller.
// ----------------------------------------------------------------------------
package gtg_pkg;

    // default parameter values
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int POS_FRAC_BITS_DEF = 16;
    localparam int MAX_STAGES        = 24;

    // cordic datapath width (33-bit difference plus gain growth)
    localparam int CW = 36;

    // fixed constants
    localparam logic [23:0] INV_GAIN_Q24 = 24'd10188014;
    localparam logic [30:0] PI_Q29       = 31'd1686629713;
    localparam logic [9:0]  WHEEL_CAP    = 10'd1000;
    localparam logic [12:0] CMD_SCALE    = 13'd5000;
    localparam logic [15:0] DIV3_RECIP   = 16'd21846;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

    // register reset values
    localparam logic [15:0] DIST_GAIN_RST  = 16'd13107;
    localparam logic [15:0] HEAD_GAIN_RST  = 16'd10486;
    localparam logic [30:0] ARRIVE_THR_RST = 31'd6554;
    localparam logic [30:0] FWD_LIMIT_RST  = 31'd27525;
    localparam logic [30:0] TURN_LIMIT_RST = 31'd11796;
    localparam logic [9:0]  WHEEL_LIM_RST  = 10'd800;

    // register indexes
    typedef enum logic [2:0] {
        REG_GOAL_X      = 3'd0,
        REG_GOAL_Y      = 3'd1,
        REG_DIST_GAIN   = 3'd2,
        REG_HEAD_GAIN   = 3'd3,
        REG_ARRIVE_THR  = 3'd4,
        REG_FWD_LIMIT   = 3'd5,
        REG_TURN_LIMIT  = 3'd6,
        REG_WHEEL_LIMIT = 3'd7
    } t_reg_idx;

    // configuration register file
    typedef struct packed {
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic [15:0]        distance_gain;
        logic [15:0]        heading_gain;
        logic [30:0]        arrive_threshold;
        logic [30:0]        forward_limit;
        logic [30:0]        turn_limit;
        logic [9:0]         wheel_limit;
    } t_cfg;

    // classified request handed from front to back
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          z;
        logic                 at_goal;
        logic [15:0]          heading;
    } t_item;

    // arctangent table, 2^31 = pi
    function automatic logic [31:0] atan_at(input int k);
        logic [31:0] a;
        unique case (k)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

endpackage

/* src/gtg_ifs.sv */
// ----------------------------------------------------------------------------
// gtg channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface gtg_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    modport source (output valid, pos_x, pos_y, heading, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface gtg_result_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] left_cmd;
    logic signed [10:0] right_cmd;
    logic               arrived;
    modport source (output valid, left_cmd, right_cmd, arrived, input ready);
    modport sink   (input valid, left_cmd, right_cmd, arrived, output ready);
endinterface

interface gtg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/gtg_front.sv */
// ----------------------------------------------------------------------------
// gtg_front
// Register file, sample intake, goal vector and cordic pre-rotation.
// ----------------------------------------------------------------------------
module gtg_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gtg_sample_if.sink           i_sample,
    gtg_cfg_if.sink              i_cfg,
    input  logic                 i_push_ready,
    output logic                 o_push_valid,
    output gtg_pkg::t_item       o_push_item,
    output gtg_pkg::t_cfg        o_cfg
);

    gtg_pkg::t_cfg  r_cfg;
    logic           r_vld;
    gtg_pkg::t_item r_item;
    gtg_pkg::t_item n_item;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               take;

    assign i_cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal_x           <= '0;
            r_cfg.goal_y           <= '0;
            r_cfg.distance_gain    <= gtg_pkg::DIST_GAIN_RST;
            r_cfg.heading_gain     <= gtg_pkg::HEAD_GAIN_RST;
            r_cfg.arrive_threshold <= gtg_pkg::ARRIVE_THR_RST;
            r_cfg.forward_limit    <= gtg_pkg::FWD_LIMIT_RST;
            r_cfg.turn_limit       <= gtg_pkg::TURN_LIMIT_RST;
            r_cfg.wheel_limit      <= gtg_pkg::WHEEL_LIM_RST;
        end else if (i_cfg.valid) begin
            unique case (gtg_pkg::t_reg_idx'(i_cfg.index))
                gtg_pkg::REG_GOAL_X:      r_cfg.goal_x <= i_cfg.data;
                gtg_pkg::REG_GOAL_Y:      r_cfg.goal_y <= i_cfg.data;
                gtg_pkg::REG_DIST_GAIN:   r_cfg.distance_gain <= i_cfg.data[15:0];
                gtg_pkg::REG_HEAD_GAIN:   r_cfg.heading_gain <= i_cfg.data[15:0];
                gtg_pkg::REG_ARRIVE_THR:  r_cfg.arrive_threshold <= i_cfg.data[30:0];
                gtg_pkg::REG_FWD_LIMIT:   r_cfg.forward_limit <= i_cfg.data[30:0];
                gtg_pkg::REG_TURN_LIMIT:  r_cfg.turn_limit <= i_cfg.data[30:0];
                gtg_pkg::REG_WHEEL_LIMIT: r_cfg.wheel_limit <= i_cfg.data[9:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

    // goal vector and half-plane classification
    always_comb begin
        dx = 33'(r_cfg.goal_x) - 33'(i_sample.pos_x);
        dy = 33'(r_cfg.goal_y) - 33'(i_sample.pos_y);
        n_item.heading = i_sample.heading;
        n_item.at_goal = (dx == '0) && (dy == '0);
        if (dx < 0) begin
            n_item.x = -gtg_pkg::CW'(dx);
            n_item.y = -gtg_pkg::CW'(dy);
            n_item.z = gtg_pkg::HALF_TURN;
        end else begin
            n_item.x = gtg_pkg::CW'(dx);
            n_item.y = gtg_pkg::CW'(dy);
            n_item.z = '0;
        end
    end

    // intake register
    assign i_sample.ready = !r_vld || i_push_ready;
    assign take           = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_sample.ready) begin
            r_vld <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_push_valid = r_vld;
    assign o_push_item  = r_item;

endmodule

/* src/gtg_queue.sv */
// ----------------------------------------------------------------------------
// gtg_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module gtg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  gtg_pkg::t_item i_push_item,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output gtg_pkg::t_item o_pop_item,
    input  logic           i_pop_ready
);

    gtg_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_item   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_item;
        end
    end

endmodule

/* src/gtg_back.sv */
// ----------------------------------------------------------------------------
// gtg_back
// Pipelined cordic, gains, clamps, wheel mixing and output register.
// ----------------------------------------------------------------------------
module gtg_back #(
    parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES_DEF,
    parameter int POS_FRAC_BITS = gtg_pkg::POS_FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gtg_pkg::t_cfg  i_cfg,
    input  logic           i_pop_valid,
    input  gtg_pkg::t_item i_pop_item,
    output logic           o_pop_ready,
    gtg_result_if.source   o_result
);

    localparam int CW  = gtg_pkg::CW;
    localparam int N   = CORDIC_STAGES;
    localparam int TSH = 60 - POS_FRAC_BITS;

    logic en;

    // whole pipe advances when the output register is free or drained
    assign en          = !o_result.valid || o_result.ready;
    assign o_pop_ready = en;

    // cordic iteration registers
    logic signed [CW-1:0] r_x  [N];
    logic signed [CW-1:0] r_y  [N];
    logic [31:0]          r_z  [N];
    logic                 r_g  [N];
    logic [15:0]          r_h  [N];
    logic                 r_v  [N];

    for (genvar k = 0; k < N; k++) begin : g_iter
        logic signed [CW-1:0] xi;
        logic signed [CW-1:0] yi;
        logic [31:0]          zi;
        logic                 gi;
        logic [15:0]          hi;
        logic                 vi;

        if (k == 0) begin : g_first
            assign xi = i_pop_item.x;
            assign yi = i_pop_item.y;
            assign zi = i_pop_item.z;
            assign gi = i_pop_item.at_goal;
            assign hi = i_pop_item.heading;
            assign vi = i_pop_valid;
        end else begin : g_next
            assign xi = r_x[k-1];
            assign yi = r_y[k-1];
            assign zi = r_z[k-1];
            assign gi = r_g[k-1];
            assign hi = r_h[k-1];
            assign vi = r_v[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en) begin
                r_v[k] <= vi;
            end
        end

        // one rotation step, direction from the sign of y
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_g[k] <= gi;
                r_h[k] <= hi;
                if (yi > 0) begin
                    r_x[k] <= xi + (yi >>> k);
                    r_y[k] <= yi - (xi >>> k);
                    r_z[k] <= zi + gtg_pkg::atan_at(k);
                end else begin
                    r_x[k] <= xi - (yi >>> k);
                    r_y[k] <= yi + (xi >>> k);
                    r_z[k] <= zi - gtg_pkg::atan_at(k);
                end
            end
        end
    end

    // stage 1: magnitude partial products and heading gain product
    logic [31:0]        bearing;
    logic [31:0]        err;
    logic signed [32:0] e_w;
    logic [16:0]        xh;
    logic [16:0]        xl;
    logic               r1_v;
    logic [40:0]        r1_ph;
    logic [40:0]        r1_pl;
    logic signed [49:0] r1_tp;

    assign xh      = r_x[N-1][33:17];
    assign xl      = r_x[N-1][16:0];
    assign bearing = r_g[N-1] ? 32'h0 : r_z[N-1];
    assign err     = bearing - {r_h[N-1], 16'h0};
    assign e_w     = (err == gtg_pkg::HALF_TURN) ? {1'b0, err} : {err[31], err};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ph <= 41'(xh) * 41'(gtg_pkg::INV_GAIN_Q24);
            r1_pl <= 41'(xl) * 41'(gtg_pkg::INV_GAIN_Q24);
            r1_tp <= 50'(e_w) * 50'($signed({1'b0, i_cfg.heading_gain}));
        end
    end

    // stage 2: distance and first turn term
    logic [58:0]        mag_sum;
    logic               r2_v;
    logic [32:0]        r2_dist;
    logic signed [32:0] r2_t1;

    assign mag_sum = {r1_ph, 17'h0} + 59'(r1_pl);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_dist <= mag_sum[56:24];
            r2_t1   <= 33'(r1_tp >>> 16);
        end
    end

    // stage 3: forward product, turn scaling product, arrival
    logic               r3_v;
    logic [48:0]        r3_fp;
    logic signed [64:0] r3_tp;
    logic               r3_arr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_fp  <= 49'(r2_dist) * 49'(i_cfg.distance_gain);
            r3_tp  <= 65'(r2_t1) * 65'($signed({1'b0, gtg_pkg::PI_Q29}));
            r3_arr <= (r2_dist < 33'(i_cfg.arrive_threshold));
        end
    end

    // stage 4: clamps on forward speed and turn term
    logic [32:0]        fwd_raw;
    logic signed [64:0] turn_raw;
    logic signed [64:0] tlim;
    logic               r4_v;
    logic signed [32:0] r4_fwd;
    logic signed [32:0] r4_turn;
    logic               r4_arr;

    assign fwd_raw  = r3_fp[48:16];
    assign turn_raw = r3_tp >>> TSH;
    assign tlim     = 65'(i_cfg.turn_limit);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_arr <= r3_arr;
            if (fwd_raw > 33'(i_cfg.forward_limit)) begin
                r4_fwd <= 33'(i_cfg.forward_limit);
            end else begin
                r4_fwd <= $signed(fwd_raw);
            end
            priority if (turn_raw > tlim) begin
                r4_turn <= 33'(tlim);
            end else if (turn_raw < -tlim) begin
                r4_turn <= -33'(tlim);
            end else begin
                r4_turn <= 33'(turn_raw);
            end
        end
    end

    // stage 5: mix and scale
    logic               r5_v;
    logic signed [47:0] r5_l;
    logic signed [47:0] r5_r;
    logic               r5_arr;
    logic signed [47:0] scl;

    assign scl = 48'($signed({1'b0, gtg_pkg::CMD_SCALE}));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_arr <= r4_arr;
            r5_l   <= (48'(r4_fwd) - 48'(r4_turn)) * scl;
            r5_r   <= (48'(r4_fwd) + 48'(r4_turn)) * scl;
        end
    end

    // stage 6: drop fraction, pre-saturate ahead of the divide by three
    function automatic logic signed [12:0] pre_sat(input logic signed [47:0] v);
        logic signed [47:0] s;
        logic signed [12:0] r;
        s = v >>> POS_FRAC_BITS;
        priority if (s > 48'sd3002) begin
            r = 13'sd3002;
        end else if (s < -48'sd3003) begin
            r = -13'sd3003;
        end else begin
            r = 13'(s);
        end
        return r;
    endfunction

    logic               r6_v;
    logic signed [12:0] r6_l;
    logic signed [12:0] r6_r;
    logic               r6_arr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_arr <= r5_arr;
            r6_l   <= pre_sat(r5_l);
            r6_r   <= pre_sat(r5_r);
        end
    end

    // stage 7: floored divide by three, wheel saturation, output register
    function automatic logic signed [10:0] div3_sat(input logic signed [12:0] v,
                                                    input logic [9:0] wl);
        logic [11:0]        u;
        logic [27:0]        p;
        logic signed [11:0] q;
        logic signed [11:0] lim;
        logic signed [10:0] r;
        u   = (v < 0) ? 12'(-v + 13'sd2) : 12'(v);
        p   = 28'(u) * 28'(gtg_pkg::DIV3_RECIP);
        q   = (v < 0) ? -$signed({1'b0, p[26:16]}) : $signed({1'b0, p[26:16]});
        lim = $signed({2'b0, wl});
        priority if (q > lim) begin
            r = 11'(lim);
        end else if (q < -lim) begin
            r = 11'(-lim);
        end else begin
            r = 11'(q);
        end
        return r;
    endfunction

    logic [9:0]         wl_cap;
    logic               r7_v;
    logic signed [10:0] r7_l;
    logic signed [10:0] r7_r;
    logic               r7_arr;

    assign wl_cap = (i_cfg.wheel_limit > gtg_pkg::WHEEL_CAP) ? gtg_pkg::WHEEL_CAP
                                                             : i_cfg.wheel_limit;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_arr <= r6_arr;
            r7_l   <= div3_sat(r6_l, wl_cap);
            r7_r   <= div3_sat(r6_r, wl_cap);
        end
    end

    // valid chain through the post stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (en) begin
            r1_v <= r_v[N-1];
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    assign o_result.valid     = r7_v;
    assign o_result.left_cmd  = r7_l;
    assign o_result.right_cmd = r7_r;
    assign o_result.arrived   = r7_arr;

endmodule

/* src/go_to_goal_diff_drive_controller_unit.sv */
// Path: intake register, queue, cordic iteration registers, then the post stages ending in the output register.
// Throughput: one sample per cycle; the cordic and post stages are fully
// pipelined, and the whole back pipe holds only while the result is not taken.
// A two-entry queue sits between intake and the back pipe.
// Reset: synchronous active-low clears all valid state and loads the register
// defaults; no clearing pass, the block takes samples right after reset.
// ----------------------------------------------------------------------------
// go_to_goal_diff_drive_controller_unit
// Go-to-goal proportional controller for a differential-drive base.
// ----------------------------------------------------------------------------
module go_to_goal_diff_drive_controller_unit #(
    parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES_DEF,
    parameter int POS_FRAC_BITS = gtg_pkg::POS_FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gtg_sample_if.sink   i_sample,
    gtg_cfg_if.sink      i_cfg,
    gtg_result_if.source o_result
);

    gtg_pkg::t_cfg  cfg;
    logic           push_valid;
    logic           push_ready;
    gtg_pkg::t_item push_item;
    logic           pop_valid;
    logic           pop_ready;
    gtg_pkg::t_item pop_item;

    // intake and classification
    gtg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (i_sample),
        .i_cfg        (i_cfg),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .o_cfg        (cfg)
    );

    // decoupling queue
    gtg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    // compute pipe
    gtg_back #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pop_valid (pop_valid),
        .i_pop_item  (pop_item),
        .o_pop_ready (pop_ready),
        .o_result    (o_result)
    );

endmodule

/* bench/gtg_checker.sv */
// ----------------------------------------------------------------------------
// gtg_checker
// Watches the sample, register and result channels of the go-to-goal unit,
// predicts each wheel command pair and arrival flag, and compares in order.
// ----------------------------------------------------------------------------
module gtg_checker
    import gtg_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gtg_sample_if.sink  i_sample_mon,
    gtg_cfg_if.sink     i_cfg_mon,
    gtg_result_if.sink  i_result_mon,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [10:0] left_cmd;
        logic signed [10:0] right_cmd;
        logic               arrived;
    } t_wheel_cmd;

    t_cfg       shadow_cfg;
    t_wheel_cmd cmd_queue[$];
    int         fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = cmd_queue.size();

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // floor division by a positive divisor
    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return q;
    endfunction

    // full controller prediction for one odometry sample
    function automatic t_wheel_cmd predict_cmd(input logic signed [31:0] px,
                                               input logic signed [31:0] py,
                                               input logic [15:0] hd);
        longint     dx, dy, x, y, xs, ys, dist_q, e, fwd, turn, lc, rc, wl, den;
        logic [31:0] z, err;
        int         stages;
        t_wheel_cmd r;
        dx = longint'(shadow_cfg.goal_x) - longint'(px);
        dy = longint'(shadow_cfg.goal_y) - longint'(py);
        x = dx;
        y = dy;
        z = 32'h0;
        stages = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES
               : (CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES;
        // pre-rotate into the right half plane
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < stages; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_at(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_at(i);
            end
        end
        if (dx == 0 && dy == 0) z = 32'h0;
        dist_q = longint'((64'(x) * 64'(INV_GAIN_Q24)) >> 24);
        // bearing error, minus half turn folds to plus half turn
        err = z - {hd, 16'h0};
        e = longint'(signed'(err));
        if (e == -64'sd2147483648) e = 64'sd2147483648;
        fwd = longint'((64'(dist_q) * 64'(shadow_cfg.distance_gain)) >> 16);
        fwd = clamp_sym(fwd, longint'(shadow_cfg.forward_limit));
        turn = (e * longint'(shadow_cfg.heading_gain)) >>> 16;
        turn = (turn * longint'(PI_Q29)) >>> (60 - POS_FRAC_BITS);
        turn = clamp_sym(turn, longint'(shadow_cfg.turn_limit));
        den = longint'(3) << POS_FRAC_BITS;
        wl = longint'(shadow_cfg.wheel_limit);
        if (wl > longint'(WHEEL_CAP)) wl = longint'(WHEEL_CAP);
        lc = clamp_sym(floor_div((fwd - turn) * 5000, den), wl);
        rc = clamp_sym(floor_div((fwd + turn) * 5000, den), wl);
        r.left_cmd  = lc[10:0];
        r.right_cmd = rc[10:0];
        r.arrived   = (dist_q < longint'(shadow_cfg.arrive_threshold));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // register shadow, request prediction and result compare
    always @(posedge i_clk) begin
        t_wheel_cmd want;
        if (!i_rst_n) begin
            shadow_cfg.goal_x           <= '0;
            shadow_cfg.goal_y           <= '0;
            shadow_cfg.distance_gain    <= DIST_GAIN_RST;
            shadow_cfg.heading_gain     <= HEAD_GAIN_RST;
            shadow_cfg.arrive_threshold <= ARRIVE_THR_RST;
            shadow_cfg.forward_limit    <= FWD_LIMIT_RST;
            shadow_cfg.turn_limit       <= TURN_LIMIT_RST;
            shadow_cfg.wheel_limit      <= WHEEL_LIM_RST;
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (t_reg_idx'(i_cfg_mon.index))
                    REG_GOAL_X:      shadow_cfg.goal_x <= i_cfg_mon.data;
                    REG_GOAL_Y:      shadow_cfg.goal_y <= i_cfg_mon.data;
                    REG_DIST_GAIN:   shadow_cfg.distance_gain <= i_cfg_mon.data[15:0];
                    REG_HEAD_GAIN:   shadow_cfg.heading_gain <= i_cfg_mon.data[15:0];
                    REG_ARRIVE_THR:  shadow_cfg.arrive_threshold <= i_cfg_mon.data[30:0];
                    REG_FWD_LIMIT:   shadow_cfg.forward_limit <= i_cfg_mon.data[30:0];
                    REG_TURN_LIMIT:  shadow_cfg.turn_limit <= i_cfg_mon.data[30:0];
                    REG_WHEEL_LIMIT: shadow_cfg.wheel_limit <= i_cfg_mon.data[9:0];
                    default: ;
                endcase
            end
            if (i_sample_mon.valid && i_sample_mon.ready)
                cmd_queue.push_back(predict_cmd(i_sample_mon.pos_x, i_sample_mon.pos_y,
                                                i_sample_mon.heading));
            if (i_result_mon.valid && i_result_mon.ready) begin
                if (cmd_queue.size() == 0) begin
                    $display("unexpected result at %0t", $realtime);
                    fail_count++;
                end else begin
                    want = cmd_queue.pop_front();
                    if (i_result_mon.left_cmd !== want.left_cmd)
                        report_mismatch("left_cmd", i_result_mon.left_cmd, want.left_cmd);
                    if (i_result_mon.right_cmd !== want.right_cmd)
                        report_mismatch("right_cmd", i_result_mon.right_cmd, want.right_cmd);
                    if (i_result_mon.arrived !== want.arrived)
                        report_mismatch("arrived", i_result_mon.arrived, want.arrived);
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

/* bench/go_to_goal_diff_drive_controller_unit_test.sv */
// ----------------------------------------------------------------------------
// go_to_goal_diff_drive_controller_unit_test
// Drives odometry samples and register writes with random gaps and
// backpressure; the checker predicts and compares every wheel command.
// ----------------------------------------------------------------------------
module go_to_goal_diff_drive_controller_unit_test;
    import gtg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = CORDIC_STAGES_DEF + 9;
    localparam int RAND_ITEMS = 574;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   hold_off;
    bit   sink_stalls;

    gtg_sample_if sample_ch ();
    gtg_result_if result_ch ();
    gtg_cfg_if    cfg_ch ();

    go_to_goal_diff_drive_controller_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch.sink),
        .i_cfg    (cfg_ch.sink),
        .o_result (result_ch.source)
    );

    gtg_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample_mon (sample_ch.sink),
        .i_cfg_mon    (cfg_ch.sink),
        .i_result_mon (result_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    // result side backpressure, with one long hold-off on request
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                result_ch.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            if (sink_stalls && $urandom_range(0, 2) == 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [31:0] px, input logic [31:0] py,
                               input logic [15:0] hd, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.pos_x   <= px;
        sample_ch.pos_y   <= py;
        sample_ch.heading <= hd;
        do @(posedge i_clk); while (!sample_ch.ready);
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // one register setting per phase, extremes first and last
    task automatic load_setting(input int phase);
        case (phase)
            0: begin
                write_reg(REG_GOAL_X, 32'h7FFF_FFFF);
                write_reg(REG_GOAL_Y, 32'h8000_0000);
                write_reg(REG_DIST_GAIN, 32'hFFFF);
                write_reg(REG_HEAD_GAIN, 32'hFFFF);
                write_reg(REG_ARRIVE_THR, 32'h7FFF_FFFF);
                write_reg(REG_FWD_LIMIT, 32'h7FFF_FFFF);
                write_reg(REG_TURN_LIMIT, 32'h7FFF_FFFF);
                write_reg(REG_WHEEL_LIMIT, 32'h3FF);
            end
            1: begin
                write_reg(REG_GOAL_X, 32'h8000_0000);
                write_reg(REG_GOAL_Y, 32'h7FFF_FFFF);
                write_reg(REG_DIST_GAIN, 32'h0);
                write_reg(REG_HEAD_GAIN, 32'h0);
                write_reg(REG_ARRIVE_THR, 32'h0);
                write_reg(REG_FWD_LIMIT, 32'h0);
                write_reg(REG_TURN_LIMIT, 32'h0);
                write_reg(REG_WHEEL_LIMIT, 32'h0);
            end
            default: begin
                write_reg(REG_GOAL_X, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h60000));
                write_reg(REG_GOAL_Y, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h60000));
                write_reg(REG_DIST_GAIN, $urandom);
                write_reg(REG_HEAD_GAIN, $urandom);
                write_reg(REG_ARRIVE_THR, $urandom_range(0, 32'h4_0000));
                write_reg(REG_FWD_LIMIT, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h2_0000));
                write_reg(REG_TURN_LIMIT, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h2_0000));
                write_reg(REG_WHEEL_LIMIT, $urandom_range(0, 1023));
            end
        endcase
    endtask

    // random sample, often close to the goal so arrival and small errors occur
    task automatic send_random(input bit gaps);
        logic [31:0] px, py;
        case ($urandom_range(0, 3))
            0: begin
                px = $urandom;
                py = $urandom;
            end
            1: begin
                px = u_checker.shadow_cfg.goal_x + $urandom_range(0, 16) - 8;
                py = u_checker.shadow_cfg.goal_y + $urandom_range(0, 16) - 8;
            end
            default: begin
                px = u_checker.shadow_cfg.goal_x + $urandom_range(0, 32'h6_0000) - 32'h3_0000;
                py = u_checker.shadow_cfg.goal_y + $urandom_range(0, 32'h6_0000) - 32'h3_0000;
            end
        endcase
        send_sample(px, py, 16'($urandom), gaps);
    endtask

    initial begin
        hold_off    = 1'b0;
        sink_stalls = 1'b0;
        i_rst_n         <= 1'b0;
        sample_ch.valid <= 1'b0;
        sample_ch.pos_x <= '0;
        sample_ch.pos_y <= '0;
        sample_ch.heading <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_GOAL_X;
        cfg_ch.data     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, goal reached, minus half turn, extremes
        send_sample(32'h0, 32'h0, 16'h0, 1'b0);
        send_sample(32'h0, 32'h0, 16'h8000, 1'b0);
        send_sample(32'h1_0000, 32'h0, 16'h0, 1'b0);
        send_sample(32'h1_0000, 32'h0, 16'h8000, 1'b0);
        send_sample(32'h0, 32'h1_0000, 16'h7FFF, 1'b0);
        send_sample(32'h0, 32'hFFFF_0000, 16'h4000, 1'b0);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hC000, 1'b0);
        send_sample(32'h8000_0000, 32'h8000_0000, 16'hFFFF, 1'b0);
        send_sample(32'h0000_1000, 32'h0, 16'h0, 1'b0);
        drain();
        load_setting(0);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 1'b0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 1'b0);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 1'b0);
        send_sample(32'h0, 32'h0, 16'hAAAA, 1'b0);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h5555, 1'b0);
        drain();
        load_setting(1);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 16'h1234, 1'b0);
        send_sample(32'h0, 32'h0, 16'h8000, 1'b0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 1'b0);

        // long result hold-off while samples keep coming
        hold_off = 1'b1;
        repeat (60) send_random(1'b0);
        drain();

        // random phases with idling on both sides
        sink_stalls = 1'b1;
        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 6) load_setting(0); else load_setting(2);
            for (int n = 0; n < RAND_ITEMS / 7; n++) begin
                send_random(n % 40 < 30);
                if (n == 45) begin
                    sample_ch.valid <= 1'b0;
                    while (pending != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("go_to_goal_diff_drive_controller_unit test passed");
        else
            $display("go_to_goal_diff_drive_controller_unit test failed");
        $finish;
    end

    initial begin
        #400000;
        $display("go_to_goal_diff_drive_controller_unit test failed");
        $finish;
    end

endmodule
